>>> sv/brb_pkg.sv
// Shared constants, types and codes of the byte ring buffer.
package brb_pkg;

   // Storage and field widths.
   localparam int DEPTH       = 1024;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int RING_W      = IDX_W + 1;
   localparam int DATA_W      = 8;
   localparam int CNT_W       = 10;
   localparam int MODE_W      = 3;
   localparam int MAX_BURST   = 64;
   localparam int BURST_W     = $clog2(MAX_BURST + 1);
   localparam int CAP_RESET   = 1023;

   // Command queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

   // Mode codes as they arrive on the request channel.
   localparam logic [MODE_W-1:0] MODE_PUT   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_GET   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SPY   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_SKIP  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_FLUSH = 3'd4;

   // Operation after classification by the front.
   typedef enum logic [2:0] {
      OP_PUT,
      OP_GET,
      OP_SPY,
      OP_SKIP,
      OP_FLUSH,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [DATA_W-1:0]   data;
      logic [CNT_W-1:0]    count;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_ADVANCE = 3'b010,
      ST_BURST   = 3'b100
   } back_state_type;

endpackage

>>> sv/byte_ring_buffer.sv
// Top level of the byte ring buffer: capacity register, front, back and checks.
//
// A circular byte buffer of capacity plus one slots, one always left free. Put,
// skip, flush and unused modes each give one response beat; a get or spy gives n
// beats, n the smallest of its count, the occupancy and 64, or one data-less beat
// when n is zero. Data beats come one per cycle from the registered read port of
// the byte store while the response is not stalled, and the back takes one
// request at a time. A two-entry command queue lets requests keep arriving while a
// burst is streaming out. Every beat of one request reports the indexes and
// occupancy as they stand after that request. Writing the capacity register
// also returns both indexes to zero, and may only be done when the block is
// idle. The byte store is not cleared after reset; no slot is read before it
// has been written unless a skip has moved the read index past the write index.
module byte_ring_buffer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [brb_pkg::MODE_W-1:0]    req_mode,
   input  logic [brb_pkg::DATA_W-1:0]    req_data_in,
   input  logic [brb_pkg::CNT_W-1:0]     req_count,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [brb_pkg::DATA_W-1:0]    rsp_data_out,
   output logic                          rsp_data_valid,
   output logic                          rsp_last,
   output logic                          rsp_accepted,
   output logic                          rsp_rejected,
   output logic [brb_pkg::IDX_W-1:0]     rsp_occupancy,
   output logic                          rsp_empty_res,
   output logic [brb_pkg::IDX_W-1:0]     rsp_read_index,
   output logic [brb_pkg::IDX_W-1:0]     rsp_write_index,
   input  logic                          csr_we,
   input  logic [brb_pkg::CNT_W-1:0]     csr_wdata
);
   import brb_pkg::*;

   logic [CNT_W-1:0]   cap_ff;
   logic [CNT_W-1:0]   cap_in;
   logic [RING_W-1:0]  ring_size;
   logic               q_valid;
   item_type           q_item;
   logic               q_pop;

   // The capacity register takes its value on any cycle the write enable is high.
   assign cap_in = csr_we ? csr_wdata : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CNT_W'(CAP_RESET);
      end else begin
         cap_ff <= cap_in;
      end
   end

   // Ring size is capacity plus one, with a floor of two slots so that a zero
   // capacity still leaves one free slot beside one usable slot.
   assign ring_size = (cap_ff == '0) ? RING_W'(2) : RING_W'(cap_ff) + 1'b1;

   brb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_mode    (req_mode),
      .req_data_in (req_data_in),
      .req_count   (req_count),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop)
   );

   brb_back u_back (
      .clock           (clock),
      .reset           (reset),
      .ring_size       (ring_size),
      .csr_clear       (csr_we),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data_out    (rsp_data_out),
      .rsp_data_valid  (rsp_data_valid),
      .rsp_last        (rsp_last),
      .rsp_accepted    (rsp_accepted),
      .rsp_rejected    (rsp_rejected),
      .rsp_occupancy   (rsp_occupancy),
      .rsp_empty_res   (rsp_empty_res),
      .rsp_read_index  (rsp_read_index),
      .rsp_write_index (rsp_write_index)
   );

`ifndef SYNTHESIS
   // The back never takes a command from an empty queue.
   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("command taken from an empty queue");

   // A beat cannot be both accepted and rejected.
   a_acc_rej_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_accepted && rsp_rejected))
      else $error("beat both accepted and rejected");

   // Data beats carry no put or skip outcome.
   a_data_no_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data_valid) |-> (!rsp_accepted && !rsp_rejected))
      else $error("data beat carries an outcome flag");

   // A beat without data is always the only beat of its request.
   a_single_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data_valid) |-> rsp_last)
      else $error("non-data beat not marked last");

   // Both indexes stay inside the ring.
   a_index_in_ring: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((RING_W'(rsp_read_index) < ring_size)
                     && (RING_W'(rsp_write_index) < ring_size)))
      else $error("index beyond the ring size");
`endif

endmodule

>>> sv/brb_front.sv
// Front of the byte ring buffer: takes request beats, classifies them and queues them.
module brb_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [brb_pkg::MODE_W-1:0]    req_mode,
   input  logic [brb_pkg::DATA_W-1:0]    req_data_in,
   input  logic [brb_pkg::CNT_W-1:0]     req_count,
   output logic                          q_valid,
   output brb_pkg::item_type             q_item,
   input  logic                          q_pop
);
   import brb_pkg::*;

   item_type            q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wptr_ff;
   logic [QPTR_W-1:0]   wptr_in;
   logic [QPTR_W-1:0]   rptr_ff;
   logic [QPTR_W-1:0]   rptr_in;
   logic [QFILL_W-1:0]  fill_ff;
   logic [QFILL_W-1:0]  fill_in;
   logic                push;
   item_type            classified;

   // Unused mode codes become a no-operation that still answers once.
   always_comb begin
      classified.data  = req_data_in;
      classified.count = req_count;
      unique case (req_mode)
         MODE_PUT:   classified.op = OP_PUT;
         MODE_GET:   classified.op = OP_GET;
         MODE_SPY:   classified.op = OP_SPY;
         MODE_SKIP:  classified.op = OP_SKIP;
         MODE_FLUSH: classified.op = OP_FLUSH;
         default:    classified.op = OP_NOP;
      endcase
   end

   assign req_stall = (fill_ff == QFILL_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (fill_ff != '0);
   assign q_item    = q_ff[rptr_ff];

   always_comb begin
      wptr_in = push  ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = q_pop ? rptr_ff + 1'b1 : rptr_ff;
      fill_in = fill_ff;
      if (push && !q_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!push && q_pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wptr_ff] <= classified;
      end
   end

endmodule

>>> sv/brb_back.sv
// Back of the byte ring buffer: byte store, ring indexes and the response register.
module brb_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [brb_pkg::RING_W-1:0]    ring_size,
   input  logic                          csr_clear,
   input  logic                          q_valid,
   input  brb_pkg::item_type             q_item,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [brb_pkg::DATA_W-1:0]    rsp_data_out,
   output logic                          rsp_data_valid,
   output logic                          rsp_last,
   output logic                          rsp_accepted,
   output logic                          rsp_rejected,
   output logic [brb_pkg::IDX_W-1:0]     rsp_occupancy,
   output logic                          rsp_empty_res,
   output logic [brb_pkg::IDX_W-1:0]     rsp_read_index,
   output logic [brb_pkg::IDX_W-1:0]     rsp_write_index
);
   import brb_pkg::*;

   logic [DATA_W-1:0]   mem [DEPTH];

   back_state_type      state_ff, state_in;
   logic [IDX_W-1:0]    rd_ff, rd_in;
   logic [IDX_W-1:0]    wr_ff, wr_in;
   logic [IDX_W-1:0]    p_ff, p_in;
   logic [BURST_W-1:0]  left_ff, left_in;
   logic                rdv_ff, rdv_in;
   logic                rlast_ff, rlast_in;
   logic [DATA_W-1:0]   rdata_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   data_ff, data_in;
   logic                dvalid_ff, dvalid_in;
   logic                last_ff, last_in;
   logic                acc_ff, acc_in;
   logic                rej_ff, rej_in;

   logic [RING_W-1:0]   rd_ext, wr_ext;
   logic [RING_W-1:0]   held_full;
   logic [IDX_W-1:0]    held;
   logic                space_ok;
   logic [RING_W-1:0]   wr_step;
   logic [IDX_W-1:0]    wr_next;
   logic [IDX_W-1:0]    min_cnt;
   logic [BURST_W-1:0]  burst_n;
   logic                skip_ok;
   logic [RING_W-1:0]   skip_sum;
   logic [IDX_W-1:0]    skip_rd;
   logic [RING_W-1:0]   adv_sum;
   logic [IDX_W-1:0]    adv_rd;
   logic [RING_W-1:0]   p_step;
   logic [IDX_W-1:0]    p_next;
   logic                rsp_free;
   logic                move;
   logic                issue;
   logic                mem_we;
   logic                burst_busy;

   // Bytes held: the indexes always stay below the ring size.
   assign rd_ext    = {1'b0, rd_ff};
   assign wr_ext    = {1'b0, wr_ff};
   assign held_full = (wr_ff >= rd_ff) ? wr_ext - rd_ext : wr_ext + ring_size - rd_ext;
   assign held      = held_full[IDX_W-1:0];
   assign space_ok  = (held_full + 1'b1) < ring_size;

   assign wr_step = wr_ext + 1'b1;
   assign wr_next = (wr_step >= ring_size) ? '0 : wr_step[IDX_W-1:0];

   // Burst length is the smallest of request, occupancy and the burst limit.
   assign min_cnt = (IDX_W'(q_item.count) < held) ? IDX_W'(q_item.count) : held;
   assign burst_n = (min_cnt > IDX_W'(MAX_BURST)) ? BURST_W'(MAX_BURST)
                                                   : min_cnt[BURST_W-1:0];

   // A skip does not look at occupancy, only at the ring size.
   assign skip_ok  = {1'b0, q_item.count} < ring_size;
   assign skip_sum = rd_ext + {1'b0, q_item.count};
   assign skip_rd  = (skip_sum >= ring_size) ? IDX_W'(skip_sum - ring_size)
                                             : skip_sum[IDX_W-1:0];

   assign adv_sum = rd_ext + RING_W'(left_ff);
   assign adv_rd  = (adv_sum >= ring_size) ? IDX_W'(adv_sum - ring_size)
                                           : adv_sum[IDX_W-1:0];

   assign p_step = {1'b0, p_ff} + 1'b1;
   assign p_next = (p_step >= ring_size) ? '0 : p_step[IDX_W-1:0];

   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign move       = rdv_ff && rsp_free;
   assign burst_busy = (state_ff == ST_ADVANCE) || (state_ff == ST_BURST);
   assign issue      = burst_busy && (left_ff != '0) && (!rdv_ff || move);

   always_comb begin
      state_in     = state_ff;
      rd_in        = rd_ff;
      wr_in        = wr_ff;
      p_in         = p_ff;
      left_in      = left_ff;
      rdv_in       = rdv_ff;
      rlast_in     = rlast_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      data_in      = data_ff;
      dvalid_in    = dvalid_ff;
      last_in      = last_ff;
      acc_in       = acc_ff;
      rej_in       = rej_ff;
      mem_we       = 1'b0;
      q_pop        = 1'b0;

      if (move) begin
         rdv_in       = 1'b0;
         rsp_valid_in = 1'b1;
         data_in      = rdata_ff;
         dvalid_in    = 1'b1;
         last_in      = rlast_ff;
         acc_in       = 1'b0;
         rej_in       = 1'b0;
      end

      unique case (state_ff) inside
         ST_IDLE: begin
            if (q_valid && rsp_free && !rdv_ff) begin
               q_pop        = 1'b1;
               rsp_valid_in = 1'b1;
               data_in      = '0;
               dvalid_in    = 1'b0;
               last_in      = 1'b1;
               acc_in       = 1'b0;
               rej_in       = 1'b0;
               case (q_item.op) inside
                  OP_PUT: begin
                     if (space_ok) begin
                        mem_we = 1'b1;
                        wr_in  = wr_next;
                        acc_in = 1'b1;
                     end else begin
                        rej_in = 1'b1;
                     end
                  end
                  OP_GET, OP_SPY: begin
                     if (burst_n != '0) begin
                        rsp_valid_in = 1'b0;
                        p_in         = rd_ff;
                        left_in      = burst_n;
                        state_in     = (q_item.op == OP_GET) ? ST_ADVANCE : ST_BURST;
                     end
                  end
                  OP_SKIP: begin
                     if (skip_ok) begin
                        rd_in  = skip_rd;
                        acc_in = 1'b1;
                     end else begin
                        rej_in = 1'b1;
                     end
                  end
                  OP_FLUSH: begin
                     rd_in = '0;
                     wr_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ADVANCE, ST_BURST: begin
            if (state_ff == ST_ADVANCE) begin
               rd_in = adv_rd;
            end
            if (issue) begin
               p_in     = p_next;
               left_in  = left_ff - 1'b1;
               rdv_in   = 1'b1;
               rlast_in = (left_ff == BURST_W'(1));
            end
            if (issue && left_ff == BURST_W'(1)) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_BURST;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_clear) begin
         rd_in = '0;
         wr_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_ff        <= '0;
         wr_ff        <= '0;
         left_ff      <= '0;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_ff        <= rd_in;
         wr_ff        <= wr_in;
         left_ff      <= left_in;
         rdv_ff       <= rdv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff      <= p_in;
      rlast_ff  <= rlast_in;
      data_ff   <= data_in;
      dvalid_ff <= dvalid_in;
      last_ff   <= last_in;
      acc_ff    <= acc_in;
      rej_ff    <= rej_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_ff] <= q_item.data;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rdata_ff <= mem[p_ff];
      end
   end

   // The index fields are live; while a beat is held only a capacity write moves them.
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data_out    = data_ff;
   assign rsp_data_valid  = dvalid_ff;
   assign rsp_last        = last_ff;
   assign rsp_accepted    = acc_ff;
   assign rsp_rejected    = rej_ff;
   assign rsp_occupancy   = held;
   assign rsp_empty_res   = (rd_ff == wr_ff);
   assign rsp_read_index  = rd_ff;
   assign rsp_write_index = wr_ff;

endmodule
